@@ sv/dpa_pkg.sv @@
// Shared types and constants for the determinant pair alignment block.
`timescale 1ns / 1ps

package dpa_pkg;

    localparam int MAX_ELECTRONS = 16;
    localparam int ORBITAL_BITS  = 4;
    localparam int LIST_W        = MAX_ELECTRONS * ORBITAL_BITS;
    localparam int LANE_IDX_W    = $clog2(MAX_ELECTRONS);
    localparam int COUNT_W       = $clog2(MAX_ELECTRONS + 1);
    localparam int STATE_IDX_W   = 16;

    typedef logic [MAX_ELECTRONS-1:0][ORBITAL_BITS-1:0] t_dpa_list;

    // One input transfer.
    typedef struct packed {
        logic [STATE_IDX_W-1:0] bra_index;
        logic [STATE_IDX_W-1:0] ket_index;
        logic [LIST_W-1:0]      bra_orbitals;
        logic [LIST_W-1:0]      ket_orbitals;
    } t_dpa_in;

    // One output transfer.
    typedef struct packed {
        logic [STATE_IDX_W-1:0] pair_bra_index;
        logic [STATE_IDX_W-1:0] pair_ket_index;
        logic [LIST_W-1:0]      bra_reordered;
        logic [LIST_W-1:0]      ket_reordered;
        logic                   sign_negative;
        logic [COUNT_W-1:0]     unpaired_count;
    } t_dpa_out;

    // Working state of one pair as it moves down the pipeline.
    typedef struct packed {
        logic [STATE_IDX_W-1:0] bra_index;
        logic [STATE_IDX_W-1:0] ket_index;
        t_dpa_list              bra;
        t_dpa_list              ket;
        logic                   neg;
        logic [COUNT_W-1:0]     unpaired;
    } t_dpa_work;

    // Pipeline control shared by every stage.
    typedef struct packed {
        logic                     en;
        logic [MAX_ELECTRONS-1:0] mask;
    } t_dpa_ctrl;

endpackage

@@ sv/determinant_pair_alignment_core.sv @@
// Top level: determinant pair alignment pipeline with config register.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_stall) carries a bra/ket pair of orbital
//   lists with their state numbers; a transfer happens when valid is high and
//   stall is low. Output channel (o_out_valid / i_out_stall) returns one result
//   per pair, in order: reordered lists, sign and unpaired count.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the electron count; it is
//   always ready. Write it only while no pair is in flight. Counts above
//   MAX_ELECTRONS saturate; zero yields all-zero lists, sign and count.
//   There is one pipeline stage per alignment step and one per compaction step,
//   the last stage being the output register. Throughput is one pair per cycle
//   while the receiver does not stall; each alignment stage compares all ket
//   lanes in parallel and merges them through a priority select.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   o_in_stall rises; it drops as soon as the result is taken.
//   Reset (synchronous, active low) empties the pipeline and sets the
//   electron count to 1.
module determinant_pair_alignment_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  dpa_pkg::t_dpa_in             i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output dpa_pkg::t_dpa_out            o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [dpa_pkg::COUNT_W-1:0]  i_cfg_data
);
    import dpa_pkg::*;

    localparam int N_STAGES = 2 * MAX_ELECTRONS;

    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  lanes;
    t_dpa_ctrl           ctrl;
    t_dpa_work           entry;
    logic [N_STAGES:0]   valid;
    t_dpa_work           work [N_STAGES+1];

    // Config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    // Saturated lane count
    assign lanes = (r_count > COUNT_W'(MAX_ELECTRONS)) ? COUNT_W'(MAX_ELECTRONS) : r_count;

    // Global advance (hold everything while a result waits on a stall) and active-lane mask
    always_comb begin
        ctrl.en = !(o_out_valid && i_out_stall);
        for (int l = 0; l < MAX_ELECTRONS; l++) begin
            ctrl.mask[l] = COUNT_W'(l) < lanes;
        end
    end

    assign o_in_stall = !ctrl.en;

    // Unpack the input, zeroing unused lanes
    always_comb begin
        entry.bra_index = i_in_data.bra_index;
        entry.ket_index = i_in_data.ket_index;
        entry.neg       = 1'b0;
        entry.unpaired  = '0;
        for (int l = 0; l < MAX_ELECTRONS; l++) begin
            entry.bra[l] = ctrl.mask[l] ?
                i_in_data.bra_orbitals[l*ORBITAL_BITS +: ORBITAL_BITS] : '0;
            entry.ket[l] = ctrl.mask[l] ?
                i_in_data.ket_orbitals[l*ORBITAL_BITS +: ORBITAL_BITS] : '0;
        end
    end

    assign valid[0] = i_in_valid;
    assign work[0]  = entry;

    // Alignment stages, then compaction stages
    for (genvar g = 0; g < MAX_ELECTRONS; g++) begin : g_align
        dpa_align_stage u_align (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_step  (LANE_IDX_W'(g)),
            .i_valid (valid[g]),
            .i_work  (work[g]),
            .o_valid (valid[g+1]),
            .o_work  (work[g+1])
        );
    end

    for (genvar g = 0; g < MAX_ELECTRONS; g++) begin : g_compact
        dpa_compact_stage u_compact (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_step  (LANE_IDX_W'(g)),
            .i_valid (valid[MAX_ELECTRONS+g]),
            .i_work  (work[MAX_ELECTRONS+g]),
            .o_valid (valid[MAX_ELECTRONS+g+1]),
            .o_work  (work[MAX_ELECTRONS+g+1])
        );
    end

    // Last stage register drives the output channel
    assign o_out_valid                = valid[N_STAGES];
    assign o_out_data.pair_bra_index  = work[N_STAGES].bra_index;
    assign o_out_data.pair_ket_index  = work[N_STAGES].ket_index;
    assign o_out_data.bra_reordered   = work[N_STAGES].bra;
    assign o_out_data.ket_reordered   = work[N_STAGES].ket;
    assign o_out_data.sign_negative   = work[N_STAGES].neg;
    assign o_out_data.unpaired_count  = work[N_STAGES].unpaired;

endmodule

@@ sv/dpa_align_stage.sv @@
// One alignment step: lanes compare one bra orbital against every active ket lane.
`timescale 1ns / 1ps

module dpa_align_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dpa_pkg::t_dpa_ctrl           i_ctrl,
    input  logic [dpa_pkg::LANE_IDX_W-1:0] i_step,
    input  logic                         i_valid,
    input  dpa_pkg::t_dpa_work           i_work,
    output logic                         o_valid,
    output dpa_pkg::t_dpa_work           o_work
);
    import dpa_pkg::*;

    logic [MAX_ELECTRONS-1:0] hit;
    logic [LANE_IDX_W-1:0]    sel;
    logic                     found;
    t_dpa_work                n_work;
    logic                     r_valid;
    t_dpa_work                r_work;

    // Per-lane compare against the bra orbital of this step
    always_comb begin
        for (int l = 0; l < MAX_ELECTRONS; l++) begin
            hit[l] = i_ctrl.mask[l] && (i_work.ket[l] == i_work.bra[i_step]);
        end
    end

    // Merge: lowest matching ket lane wins
    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int l = MAX_ELECTRONS - 1; l >= 0; l--) begin
            if (hit[l]) begin
                sel   = LANE_IDX_W'(l);
                found = 1'b1;
            end
        end
    end

    // Swap the match into place, toggle sign on a real swap
    always_comb begin
        n_work = i_work;
        if (i_ctrl.mask[i_step] && found && (sel != i_step)) begin
            n_work.ket[i_step] = i_work.ket[sel];
            n_work.ket[sel]    = i_work.ket[i_step];
            n_work.neg         = ~i_work.neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

@@ sv/dpa_compact_stage.sv @@
// One compaction step: moves a mismatched lane to the front and counts it.
`timescale 1ns / 1ps

module dpa_compact_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dpa_pkg::t_dpa_ctrl           i_ctrl,
    input  logic [dpa_pkg::LANE_IDX_W-1:0] i_step,
    input  logic                         i_valid,
    input  dpa_pkg::t_dpa_work           i_work,
    output logic                         o_valid,
    output dpa_pkg::t_dpa_work           o_work
);
    import dpa_pkg::*;

    logic [LANE_IDX_W-1:0] dst;
    t_dpa_work             n_work;
    logic                  r_valid;
    t_dpa_work             r_work;

    // Count never exceeds the step index, so the low bits address a lane
    assign dst = i_work.unpaired[LANE_IDX_W-1:0];

    always_comb begin
        n_work = i_work;
        if (i_ctrl.mask[i_step] && (i_work.bra[i_step] != i_work.ket[i_step])) begin
            if (dst != i_step) begin
                n_work.bra[i_step] = i_work.bra[dst];
                n_work.bra[dst]    = i_work.bra[i_step];
                n_work.ket[i_step] = i_work.ket[dst];
                n_work.ket[dst]    = i_work.ket[i_step];
            end
            n_work.unpaired = i_work.unpaired + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

@@ verif/determinant_pair_alignment_checker.sv @@
// Checker for the determinant pair alignment block: predicts each result and compares it.
`timescale 1ns / 1ps

module determinant_pair_alignment_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  dpa_pkg::t_dpa_in            i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  dpa_pkg::t_dpa_out           i_out_data,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [dpa_pkg::COUNT_W-1:0] i_cfg_data,
    output int                          o_failures,
    output int                          o_outstanding
);
    import dpa_pkg::*;

    logic [COUNT_W-1:0] lane_count;
    t_dpa_out           expected_pairs[$];
    int                 failures = 0;

    assign o_failures = failures;

    // Maximum-coincidence alignment of one pair, then compaction of unpaired lanes.
    function automatic t_dpa_out align_pair(t_dpa_in pair, logic [COUNT_W-1:0] count);
        t_dpa_list        bra;
        t_dpa_list        ket;
        logic [ORBITAL_BITS-1:0] tmp;
        int               used;
        int               front;
        bit               neg;
        bit               found;
        t_dpa_out         res;
        bra   = '0;
        ket   = '0;
        neg   = 1'b0;
        front = 0;
        used  = (count > MAX_ELECTRONS) ? MAX_ELECTRONS : int'(count);
        for (int k = 0; k < used; k++) begin
            bra[k] = pair.bra_orbitals[k*ORBITAL_BITS +: ORBITAL_BITS];
            ket[k] = pair.ket_orbitals[k*ORBITAL_BITS +: ORBITAL_BITS];
        end
        // first matching ket lane is swapped into the bra position
        for (int k = 0; k < used; k++) begin
            found = 1'b0;
            for (int l = 0; l < used; l++) begin
                if (!found && bra[k] == ket[l]) begin
                    found = 1'b1;
                    if (k != l) begin
                        tmp    = ket[k];
                        ket[k] = ket[l];
                        ket[l] = tmp;
                        neg    = ~neg;
                    end
                end
            end
        end
        // unpaired lanes move to the front, order kept
        for (int k = 0; k < used; k++) begin
            if (bra[k] != ket[k]) begin
                if (k != front) begin
                    tmp        = bra[k];
                    bra[k]     = bra[front];
                    bra[front] = tmp;
                    tmp        = ket[k];
                    ket[k]     = ket[front];
                    ket[front] = tmp;
                end
                front++;
            end
        end
        res.pair_bra_index = pair.bra_index;
        res.pair_ket_index = pair.ket_index;
        res.bra_reordered  = bra;
        res.ket_reordered  = ket;
        res.sign_negative  = neg;
        res.unpaired_count = front[COUNT_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [LIST_W-1:0] want,
                               input logic [LIST_W-1:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Watch all three channels on every rising edge
    always @(posedge i_clk) begin
        t_dpa_out want;
        if (!i_rst_n) begin
            lane_count = COUNT_W'(1);
            expected_pairs.delete();
        end else begin
            // result transfer: compare with oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_pairs.size() == 0) begin
                    failures++;
                    $display("%0t: result with nothing expected: %h", $time, i_out_data);
                end else begin
                    want = expected_pairs.pop_front();
                    check_field("pair_bra_index", LIST_W'(want.pair_bra_index),
                                LIST_W'(i_out_data.pair_bra_index));
                    check_field("pair_ket_index", LIST_W'(want.pair_ket_index),
                                LIST_W'(i_out_data.pair_ket_index));
                    check_field("bra_reordered", want.bra_reordered,
                                i_out_data.bra_reordered);
                    check_field("ket_reordered", want.ket_reordered,
                                i_out_data.ket_reordered);
                    check_field("sign_negative", LIST_W'(want.sign_negative),
                                LIST_W'(i_out_data.sign_negative));
                    check_field("unpaired_count", LIST_W'(want.unpaired_count),
                                LIST_W'(i_out_data.unpaired_count));
                end
            end
            // input transfer: predict with the current lane count
            if (i_in_valid && !i_in_stall)
                expected_pairs.push_back(align_pair(i_in_data, lane_count));
            // register write
            if (i_cfg_valid && i_cfg_ready)
                lane_count = i_cfg_data;
        end
        o_outstanding <= expected_pairs.size();
    end

endmodule

@@ verif/tb_determinant_pair_alignment_core.sv @@
// Testbench top for the determinant pair alignment block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_determinant_pair_alignment_core;
    import dpa_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 112;
    localparam int TAIL_CYCLES  = 64;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    t_dpa_in            in_data;
    logic               out_valid;
    logic               out_stall;
    t_dpa_out           out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    int failures;
    int outstanding;
    int cycles     = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int lane_limit = 1;

    always #2 clk = ~clk;

    determinant_pair_alignment_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    determinant_pair_alignment_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    // Receiver back-pressure
    always @(posedge clk) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Run watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_dpa_in make_item(logic [15:0] bra_idx, logic [15:0] ket_idx,
                                          logic [LIST_W-1:0] bra, logic [LIST_W-1:0] ket);
        t_dpa_in item;
        item.bra_index    = bra_idx;
        item.ket_index    = ket_idx;
        item.bra_orbitals = bra;
        item.ket_orbitals = ket;
        return item;
    endfunction

    // Random pair: mostly a permuted ket with a few orbitals replaced, some pure noise
    function automatic t_dpa_in make_pair(int used);
        t_dpa_in item;
        int      pool[MAX_ELECTRONS];
        int      j;
        int      m;
        int      tmp;
        item.bra_index    = STATE_IDX_W'($urandom);
        item.ket_index    = STATE_IDX_W'($urandom);
        item.bra_orbitals = {$urandom, $urandom};
        item.ket_orbitals = {$urandom, $urandom};
        if ($urandom_range(99) < 80 && used > 0) begin
            for (int i = 0; i < MAX_ELECTRONS; i++)
                pool[i] = i;
            for (int i = MAX_ELECTRONS - 1; i > 0; i--) begin
                j       = $urandom_range(i);
                tmp     = pool[i];
                pool[i] = pool[j];
                pool[j] = tmp;
            end
            for (int i = 0; i < used; i++) begin
                item.bra_orbitals[i*ORBITAL_BITS +: ORBITAL_BITS] = ORBITAL_BITS'(pool[i]);
                item.ket_orbitals[i*ORBITAL_BITS +: ORBITAL_BITS] = ORBITAL_BITS'(pool[i]);
            end
            // scramble ket order
            m = $urandom_range(used);
            for (int s = 0; s < m; s++) begin
                j   = $urandom_range(used - 1);
                tmp = $urandom_range(used - 1);
                {item.ket_orbitals[j*ORBITAL_BITS +: ORBITAL_BITS],
                 item.ket_orbitals[tmp*ORBITAL_BITS +: ORBITAL_BITS]} =
                    {item.ket_orbitals[tmp*ORBITAL_BITS +: ORBITAL_BITS],
                     item.ket_orbitals[j*ORBITAL_BITS +: ORBITAL_BITS]};
            end
            // excitations: fresh orbitals or possibly repeated ones
            m = $urandom_range(3);
            for (int s = 0; s < m; s++) begin
                j = $urandom_range(used - 1);
                if (used < MAX_ELECTRONS && $urandom_range(1))
                    item.ket_orbitals[j*ORBITAL_BITS +: ORBITAL_BITS] =
                        ORBITAL_BITS'(pool[$urandom_range(MAX_ELECTRONS - 1, used)]);
                else
                    item.ket_orbitals[j*ORBITAL_BITS +: ORBITAL_BITS] =
                        ORBITAL_BITS'($urandom);
            end
        end
        return item;
    endfunction

    // One input transfer, with random sender gaps ahead of it
    task automatic send_pair(input t_dpa_in item);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_count(input int count);
        drain();
        cfg_valid  <= 1'b1;
        cfg_data   <= count[COUNT_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        lane_limit = (count > MAX_ELECTRONS) ? MAX_ELECTRONS : count;
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 50; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 8; stall_pct = 8; end
        endcase
    endtask

    initial begin
        int phase_counts[12];
        phase_counts = '{16, 1, 9, 0, 16, 4, 31, 13, 2, 16, 17, 7};
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lane count left at its reset value of one
        send_pair(make_item(16'h0000, 16'hFFFF, 64'hA5A5_A5A5_A5A5_A5A3, 64'h5A5A_5A5A_5A5A_5A53));
        send_pair(make_item(16'hFFFF, 16'h0000, 64'h0000_0000_0000_0007, 64'hFFFF_FFFF_FFFF_FFF8));

        // Directed: all sixteen lanes
        write_count(16);
        send_pair(make_item(16'h0000, 16'h0000, 64'hFEDC_BA98_7654_3210, 64'hFEDC_BA98_7654_3210));
        send_pair(make_item(16'hFFFF, 16'hFFFF, 64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF));
        send_pair(make_item(16'h1234, 16'hABCD, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF));
        send_pair(make_item(16'h8000, 16'h0001, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_pair(make_item(16'h0001, 16'h8000, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000));
        send_pair(make_item(16'h5555, 16'hAAAA, 64'hFEDC_BA98_7654_3210, 64'h0000_0000_0000_0000));
        send_pair(make_item(16'hAAAA, 16'h5555, 64'hFEDC_BA98_7654_3210, 64'h0EDC_BA98_7654_321F));
        send_pair(make_item(16'h00FF, 16'hFF00, 64'h1111_2222_3333_4444, 64'h4444_3333_2222_1111));
        send_pair(make_item(16'h0F0F, 16'hF0F0, 64'hFEDC_BA98_7654_3210, 64'hEFCD_AB89_6745_2301));

        // Directed: partial lane count with garbage in the unused lanes
        write_count(8);
        send_pair(make_item(16'h3C3C, 16'hC3C3, 64'hFFFF_FFFF_7654_3210, 64'hAAAA_AAAA_0123_4567));
        send_pair(make_item(16'hC3C3, 16'h3C3C, 64'h5555_5555_7654_3210, 64'h0000_0000_7654_32F8));

        // Directed: zero lanes, then counts that saturate
        write_count(0);
        send_pair(make_item(16'hFFFF, 16'hFFFF, 64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF));
        send_pair(make_item(16'h0000, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000));
        write_count(31);
        send_pair(make_item(16'h7777, 16'h8888, 64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF));
        send_pair(make_item(16'h8888, 16'h7777, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF));
        write_count(17);
        send_pair(make_item(16'h6969, 16'h9696, 64'hFEDC_BA98_7654_3210, 64'hFEDC_BA98_7654_3201));

        // Random phases over lane counts and idling patterns
        for (int ph = 0; ph < 12; ph++) begin
            write_count(phase_counts[ph]);
            set_idling(ph);
            repeat (PHASE_ITEMS) send_pair(make_pair(lane_limit));
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ determinant_pair_alignment_core.f @@
sv/dpa_pkg.sv
sv/dpa_align_stage.sv
sv/dpa_compact_stage.sv
sv/determinant_pair_alignment_core.sv
verif/determinant_pair_alignment_checker.sv
verif/tb_determinant_pair_alignment_core.sv
